/* rtl/tagged_fixnum_alu_core_assert.svh */
// Assertion macros for the tagged fixnum ALU core checker.
`ifndef TAGGED_FIXNUM_ALU_CORE_ASSERT_SVH
`define TAGGED_FIXNUM_ALU_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TFA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/tfa_pkg.sv */
// Shared types and constants for the tagged fixnum ALU core.
`default_nettype none
package tfa_pkg;

	localparam int FXN_W = 30;
	localparam int WORD_W = 32;
	localparam int FUNC_W = 4;
	localparam int TUSER_W = FUNC_W + 1;

	localparam logic [FUNC_W-1:0] FN_ADD = 4'd0;
	localparam logic [FUNC_W-1:0] FN_SUB = 4'd1;
	localparam logic [FUNC_W-1:0] FN_MUL = 4'd2;
	localparam logic [FUNC_W-1:0] FN_DIV = 4'd3;
	localparam logic [FUNC_W-1:0] FN_MOD = 4'd4;
	localparam logic [FUNC_W-1:0] FN_EQ = 4'd5;
	localparam logic [FUNC_W-1:0] FN_LT = 4'd6;
	localparam logic [FUNC_W-1:0] FN_NULL = 4'd7;
	localparam logic [FUNC_W-1:0] FN_PAIR = 4'd8;
	localparam logic [FUNC_W-1:0] FN_LIST = 4'd9;
	localparam logic [FUNC_W-1:0] FN_NUMBER = 4'd10;
	localparam logic [FUNC_W-1:0] FN_SYMBOL = 4'd11;

	localparam logic [1:0] TAG_FIXNUM = 2'd0;
	localparam logic [1:0] TAG_PAIR = 2'd1;
	localparam logic [1:0] TAG_SYMBOL = 2'd2;

	localparam logic [WORD_W-1:0] WORD_NIL = 32'd3;
	localparam logic [WORD_W-1:0] WORD_TRUE = 32'd7;
	localparam logic [WORD_W-1:0] WORD_ERR = 32'd11;

	localparam logic [FXN_W-1:0] FXN_MAX = 30'h1FFFFFFF;
	localparam logic [FXN_W-1:0] FXN_MIN = 30'h20000000;

	localparam int DIV_STEPS = FXN_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MULCHK,
		ST_DIV,
		ST_FIN
	} tfa_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic mulchk;
		logic div_step;
		logic fin;
	} tfa_cmd_t;

	typedef struct packed {
		logic mul_step;
		logic last;
		logic div_need;
	} tfa_sts_t;

endpackage
`default_nettype wire

/* rtl/tfa_ctrl.sv */
// Controller state machine: sequences capture, execute, multiply check, divide and result load.
`default_nettype none
module tfa_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	input  wire tfa_pkg::tfa_sts_t sts,
	output tfa_pkg::tfa_cmd_t     cmd
);
	import tfa_pkg::*;

	tfa_state_t state_q;
	tfa_state_t state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic out_vld_q;
	logic out_free;

	assign out_free = ~out_vld_q | m_axis_tready;
	assign m_axis_tvalid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			div_cnt_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (cmd.fin) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.capture = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.mul_step) begin
					state_d = ST_MULCHK;
				end else if (!sts.last) begin
					state_d = ST_IDLE;
				end else if (sts.div_need) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_MULCHK: begin
				cmd.mulchk = 1'b1;
				state_d = sts.last ? ST_FIN : ST_IDLE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

/* rtl/tfa_dp.sv */
// Datapath: call state, fold adder, multiplier, restoring divider and result word.
`default_nettype none
module tfa_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tfa_pkg::tfa_cmd_t             cmd,
	output tfa_pkg::tfa_sts_t                  sts,
	input  wire logic [tfa_pkg::WORD_W-1:0]    in_word,
	input  wire logic [tfa_pkg::TUSER_W-1:0]   in_user,
	input  wire logic                          in_last,
	output logic [tfa_pkg::WORD_W-1:0]         res_word,
	output logic                               res_err
);
	import tfa_pkg::*;

	logic [FUNC_W-1:0] fn_in_q;
	logic [WORD_W-1:0] word_q;
	logic first_q;
	logic last_q;

	logic [FXN_W-1:0] run_q;
	logic [WORD_W-1:0] first_word_q;
	logic [1:0] cnt_q;
	logic err_q;
	logic [FUNC_W-1:0] func_q;

	logic signed [2*FXN_W-1:0] prod_q;
	logic [FXN_W-1:0] rem_q;
	logic [FXN_W-1:0] quo_q;
	logic [FXN_W-1:0] dvs_q;
	logic [WORD_W-1:0] res_q;
	logic res_err_q;

	logic new_call;
	logic [FUNC_W-1:0] f;
	logic [1:0] n;
	logic arith;
	logic err_now;
	logic fold;
	logic signed [FXN_W-1:0] acc;
	logic signed [FXN_W-1:0] arg_v;
	logic [FXN_W:0] sum;
	logic sum_ok;
	logic prod_ok;
	logic [FXN_W-1:0] mag_a;
	logic [FXN_W-1:0] mag_v;
	logic [FXN_W:0] trial;
	logic q_neg;
	logic q_ovf;
	logic [FXN_W-1:0] q_val;
	logic [FXN_W-1:0] r_val;
	logic [1:0] tag;
	logic pred;
	logic [WORD_W-1:0] res_c;

	assign new_call = first_q | (cnt_q == 2'd0);
	assign f = new_call ? fn_in_q : func_q;
	assign n = new_call ? 2'd0 : cnt_q;
	assign arith = (f <= FN_MOD) | (f == FN_LT);
	assign err_now = (~new_call & err_q) | (arith & (word_q[1:0] != TAG_FIXNUM));
	assign acc = signed'(run_q);
	assign arg_v = signed'(word_q[WORD_W-1:2]);
	assign fold = (f <= FN_MUL) & (n != 2'd0) & ~err_now;
	assign sum = (f == FN_ADD) ? ({acc[FXN_W-1], acc} + {arg_v[FXN_W-1], arg_v})
	                           : ({acc[FXN_W-1], acc} - {arg_v[FXN_W-1], arg_v});
	assign sum_ok = sum[FXN_W] == sum[FXN_W-1];
	assign prod_ok = prod_q[2*FXN_W-1:FXN_W-1] == {(FXN_W+1){prod_q[FXN_W-1]}};
	assign mag_a = run_q[FXN_W-1] ? (~run_q + 1'b1) : run_q;
	assign mag_v = word_q[WORD_W-1] ? (~word_q[WORD_W-1:2] + 1'b1) : word_q[WORD_W-1:2];
	assign trial = {rem_q, quo_q[FXN_W-1]} - {1'b0, dvs_q};

	assign sts.mul_step = fold & (f == FN_MUL);
	assign sts.last = last_q;
	assign sts.div_need = ((f == FN_DIV) | (f == FN_MOD)) & (n == 2'd1) & ~err_now
		& (arg_v != '0);

	assign q_neg = run_q[FXN_W-1] ^ word_q[WORD_W-1];
	assign q_ovf = ~q_neg & quo_q[FXN_W-1];
	assign q_val = q_neg ? (~quo_q + 1'b1) : quo_q;
	assign r_val = run_q[FXN_W-1] ? (~rem_q + 1'b1) : rem_q;
	assign tag = first_word_q[1:0];

	always_comb begin
		res_c = WORD_ERR;
		pred = 1'b0;
		case (func_q)
			FN_ADD, FN_SUB, FN_MUL: begin
				if (cnt_q >= 2'd2 && !err_q) begin
					res_c = {run_q, TAG_FIXNUM};
				end
			end
			FN_DIV: begin
				if (cnt_q == 2'd2 && !err_q && arg_v != '0 && !q_ovf) begin
					res_c = {q_val, TAG_FIXNUM};
				end
			end
			FN_MOD: begin
				if (cnt_q == 2'd2 && !err_q && arg_v != '0) begin
					res_c = {r_val, TAG_FIXNUM};
				end
			end
			FN_EQ: begin
				if (cnt_q == 2'd2) begin
					res_c = (first_word_q == word_q) ? WORD_TRUE : WORD_NIL;
				end
			end
			FN_LT: begin
				if (cnt_q == 2'd2 && !err_q) begin
					res_c = (acc < arg_v) ? WORD_TRUE : WORD_NIL;
				end
			end
			FN_NULL, FN_PAIR, FN_LIST, FN_NUMBER, FN_SYMBOL: begin
				case (func_q)
					FN_NULL: pred = first_word_q == WORD_NIL;
					FN_PAIR: pred = tag == TAG_PAIR;
					FN_LIST: pred = (first_word_q == WORD_NIL) | (tag == TAG_PAIR);
					FN_NUMBER: pred = tag == TAG_FIXNUM;
					default: pred = tag == TAG_SYMBOL;
				endcase
				if (cnt_q == 2'd1) begin
					res_c = pred ? WORD_TRUE : WORD_NIL;
				end
			end
			default: begin
				res_c = WORD_ERR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
			first_word_q <= '0;
			cnt_q <= 2'd0;
			err_q <= 1'b0;
			func_q <= '0;
		end else begin
			if (cmd.exec) begin
				func_q <= f;
				if (new_call) begin
					first_word_q <= word_q;
				end
				cnt_q <= (n == 2'd3) ? 2'd3 : n + 2'd1;
				err_q <= err_now | (fold & (f != FN_MUL) & ~sum_ok);
				if (arith && n == 2'd0) begin
					run_q <= word_q[WORD_W-1:2];
				end else if (fold && f != FN_MUL && sum_ok) begin
					run_q <= sum[FXN_W-1:0];
				end
			end else if (cmd.mulchk) begin
				if (prod_ok) begin
					run_q <= prod_q[FXN_W-1:0];
				end else begin
					err_q <= 1'b1;
				end
			end else if (cmd.fin) begin
				cnt_q <= 2'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			fn_in_q <= in_user[FUNC_W-1:0];
			first_q <= in_user[FUNC_W];
			word_q <= in_word;
			last_q <= in_last;
		end
		if (cmd.exec) begin
			prod_q <= acc * arg_v;
			quo_q <= mag_a;
			rem_q <= '0;
			dvs_q <= mag_v;
		end else if (cmd.div_step) begin
			if (!trial[FXN_W]) begin
				rem_q <= trial[FXN_W-1:0];
				quo_q <= {quo_q[FXN_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[FXN_W-2:0], quo_q[FXN_W-1]};
				quo_q <= {quo_q[FXN_W-2:0], 1'b0};
			end
		end
		if (cmd.fin) begin
			res_q <= res_c;
			res_err_q <= res_c == WORD_ERR;
		end
	end

	assign res_word = res_q;
	assign res_err = res_err_q;

endmodule
`default_nettype wire

/* rtl/tagged_fixnum_alu_core.sv */
// Top level: tagged fixnum ALU core over a stream of argument words.
// Each argument word is captured, then executed; a multiply step adds a check of the product register.
// A last argument also loads the result register; divide and modulo first run the
// shared restoring divider, one quotient bit per cycle.
// The next word is taken while a result still waits in the output register.
// Asynchronous active-low reset clears call state and returns the controller to idle.
`default_nettype none
module tagged_fixnum_alu_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [tfa_pkg::WORD_W-1:0]  s_axis_tdata,  // [31:0] arg_word
	input  wire logic                        s_axis_tlast,  // arg_last
	input  wire logic [tfa_pkg::TUSER_W-1:0] s_axis_tuser,  // [3:0] func, [4] arg_first
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic [tfa_pkg::WORD_W-1:0]       m_axis_tdata,  // [31:0] result_word
	output logic                             m_axis_tuser   // [0] is_error
);
	import tfa_pkg::*;

	tfa_cmd_t cmd;
	tfa_sts_t sts;

	tfa_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	tfa_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_word  (s_axis_tdata),
		.in_user  (s_axis_tuser),
		.in_last  (s_axis_tlast),
		.res_word (m_axis_tdata),
		.res_err  (m_axis_tuser)
	);

endmodule
`default_nettype wire

/* rtl/tfa_checker.sv */
// Port-level checker for the tagged fixnum ALU core, bound to the top level.
`default_nettype none
`include "tagged_fixnum_alu_core_assert.svh"
module tfa_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        s_axis_tvalid,
	input wire logic                        s_axis_tready,
	input wire logic                        m_axis_tvalid,
	input wire logic                        m_axis_tready,
	input wire logic [tfa_pkg::WORD_W-1:0]  m_axis_tdata,
	input wire logic                        m_axis_tuser
);
	import tfa_pkg::*;

	`TFA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed while stalled")
	`TFA_ASSERT_NOW(a_err_flag, m_axis_tvalid, m_axis_tuser == (m_axis_tdata == WORD_ERR), "is_error disagrees with result word")
	`TFA_ASSERT_NOW(a_res_kind, m_axis_tvalid, m_axis_tdata[1:0] == TAG_FIXNUM || m_axis_tdata == WORD_TRUE || m_axis_tdata == WORD_NIL || m_axis_tdata == WORD_ERR, "result word is not fixnum, true, nil or error")
	`TFA_ASSERT_NEXT(a_busy_after, s_axis_tvalid && s_axis_tready, !s_axis_tready, "word taken while previous word executes")

endmodule

bind tagged_fixnum_alu_core tfa_checker u_tfa_checker (.*);
`default_nettype wire
